FILE: hw/rtl/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// ntpc_pkg
// shared types and constants of the ntp receive timestamp capture core
// ----------------------------------------------------------------------------
package ntpc_pkg;

    // stream field codes
    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_TAKE     = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_TAKE    = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_UDP_PORT     = 1'b0;
    localparam logic REG_FRESH_WINDOW = 1'b1;

    localparam logic [15:0] UDP_PORT_RST     = 16'd123;
    localparam logic [31:0] FRESH_WINDOW_RST = 32'd200000;

    // header constants
    localparam logic [15:0] VLAN_TPID     = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [4:0]  IP_OFF_PLAIN  = 5'd14;
    localparam logic [4:0]  IP_OFF_VLAN   = 5'd18;
    localparam logic [16:0] MIN_PLAIN_LEN = 17'd42;
    localparam logic [16:0] MIN_VLAN_LEN  = 17'd46;
    localparam logic [5:0]  MIN_IHL_BYTES = 6'd20;
    localparam logic [3:0]  IP_VERSION4   = 4'd4;

    // one operation handed from the parser to the ring engine
    typedef struct packed {
        logic        take;   // 1 take request, 0 frame verdict
        logic        ntp;    // verdict: frame is ntp
        logic [63:0] value;  // verdict: arrival stamp, take: current time
    } ntpc_op_t;

endpackage

FILE: hw/rtl/ntpc_ram.sv
// ----------------------------------------------------------------------------
// ntpc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ntpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/ntpc_fifo.sv
// ----------------------------------------------------------------------------
// ntpc_fifo
// short operation queue between the frame parser and the ring engine
// ----------------------------------------------------------------------------
module ntpc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ntpc_pkg::ntpc_op_t  push_op,
    input  logic                pop,
    output ntpc_pkg::ntpc_op_t  head_op,
    output logic                full,
    output logic                empty
);
    import ntpc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ntpc_op_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/ntpc_front.sv
// ----------------------------------------------------------------------------
// ntpc_front
// frame byte parser: tracks header fields and classifies at the last byte
// ----------------------------------------------------------------------------
module ntpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [71:0]         s_axis_tdata,   // frame_byte[7:0], time_value[71:8]
    input  logic                s_axis_tuser,   // command
    input  logic                s_axis_tlast,   // frame_end
    input  logic [15:0]         udp_port,
    input  logic                q_full,
    output logic                q_push,
    output ntpc_pkg::ntpc_op_t  q_op
);
    import ntpc_pkg::*;

    logic [15:0] byte_count_reg;
    logic [63:0] frame_stamp_reg;
    logic [15:0] ether_type_reg;
    logic [4:0]  ip_offset_reg;
    logic [5:0]  header_bytes_reg;
    logic        version_ok_reg;
    logic [7:0]  protocol_byte_reg;
    logic [15:0] dest_port_reg;

    logic        accept;
    logic        byte_accept;
    logic        first;
    logic [7:0]  b;
    logic [63:0] tv;
    logic [15:0] pos;
    logic [16:0] len;
    logic [63:0] stamp_next;
    logic [15:0] ether_type_next;
    logic [4:0]  ip_offset_next;
    logic [5:0]  header_bytes_next;
    logic        version_ok_next;
    logic [7:0]  protocol_byte_next;
    logic [15:0] dest_port_next;
    logic [15:0] port_pos;
    logic        ntp;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign byte_accept   = accept && (s_axis_tuser == CMD_BYTE);
    assign b             = s_axis_tdata[7:0];
    assign tv            = s_axis_tdata[71:8];
    assign pos           = byte_count_reg;
    assign first         = (pos == '0);
    assign len           = {1'b0, pos} + 17'd1;

    // header field tracking for the current byte
    always_comb
    begin
        stamp_next         = first ? tv : frame_stamp_reg;
        ether_type_next    = first ? '0 : ether_type_reg;
        ip_offset_next     = first ? IP_OFF_PLAIN : ip_offset_reg;
        header_bytes_next  = first ? '0 : header_bytes_reg;
        version_ok_next    = first ? 1'b0 : version_ok_reg;
        protocol_byte_next = first ? '0 : protocol_byte_reg;
        dest_port_next     = first ? '0 : dest_port_reg;

        if (pos == 16'd12)
        begin
            ether_type_next = {b, 8'h00};
        end
        else if (pos == 16'd13)
        begin
            ether_type_next = ether_type_next | {8'h00, b};
            if (ether_type_next == VLAN_TPID)
            begin
                ip_offset_next = IP_OFF_VLAN;
            end
        end
        else if (ip_offset_next == IP_OFF_VLAN && pos == 16'd16)
        begin
            ether_type_next = {b, 8'h00};
        end
        else if (ip_offset_next == IP_OFF_VLAN && pos == 16'd17)
        begin
            ether_type_next = ether_type_next | {8'h00, b};
        end

        if (pos == 16'(ip_offset_next))
        begin
            version_ok_next   = (b[7:4] == IP_VERSION4);
            header_bytes_next = {b[3:0], 2'b00};
        end
        if (pos == 16'(ip_offset_next) + 16'd9)
        begin
            protocol_byte_next = b;
        end

        // udp destination port sits two bytes into the udp header
        port_pos = 16'(ip_offset_next) + 16'(header_bytes_next) + 16'd2;
        if (pos > 16'(ip_offset_next))
        begin
            if (pos == port_pos)
            begin
                dest_port_next = {b, 8'h00};
            end
            if (pos == port_pos + 16'd1)
            begin
                dest_port_next = dest_port_next | {8'h00, b};
            end
        end
    end

    // verdict at the last byte
    always_comb
    begin
        ntp = 1'b1;
        if (len < MIN_PLAIN_LEN)
        begin
            ntp = 1'b0;
        end
        if (ip_offset_next == IP_OFF_VLAN && len < MIN_VLAN_LEN)
        begin
            ntp = 1'b0;
        end
        if (ether_type_next != ETYPE_IPV4 || !version_ok_next)
        begin
            ntp = 1'b0;
        end
        if (header_bytes_next < MIN_IHL_BYTES ||
            len < 17'(ip_offset_next) + 17'(header_bytes_next) + 17'd8)
        begin
            ntp = 1'b0;
        end
        if (protocol_byte_next != PROTO_UDP || dest_port_next != udp_port)
        begin
            ntp = 1'b0;
        end
    end

    assign q_push = accept && (s_axis_tuser == CMD_TAKE || s_axis_tlast);

    always_comb
    begin
        q_op.take  = (s_axis_tuser == CMD_TAKE);
        q_op.ntp   = (s_axis_tuser == CMD_BYTE) && ntp;
        q_op.value = (s_axis_tuser == CMD_TAKE) ? tv : stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            frame_stamp_reg   <= '0;
            ether_type_reg    <= '0;
            ip_offset_reg     <= IP_OFF_PLAIN;
            header_bytes_reg  <= '0;
            version_ok_reg    <= 1'b0;
            protocol_byte_reg <= '0;
            dest_port_reg     <= '0;
        end
        else if (byte_accept)
        begin
            frame_stamp_reg   <= stamp_next;
            ether_type_reg    <= ether_type_next;
            ip_offset_reg     <= ip_offset_next;
            header_bytes_reg  <= header_bytes_next;
            version_ok_reg    <= version_ok_next;
            protocol_byte_reg <= protocol_byte_next;
            dest_port_reg     <= dest_port_next;
            if (s_axis_tlast)
            begin
                byte_count_reg <= '0;
            end
            else if (byte_count_reg != 16'hffff)
            begin
                byte_count_reg <= byte_count_reg + 16'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/ntpc_back.sv
// ----------------------------------------------------------------------------
// ntpc_back
// ring engine: stores ntp stamps and walks the ring on take requests
// ----------------------------------------------------------------------------
module ntpc_back #(
    parameter int RING_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         fresh_window,
    input  logic                q_empty,
    input  ntpc_pkg::ntpc_op_t  q_head,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [71:0]         m_axis_tdata,   // is_ntp[0], stamp_found[1], stamp_value[65:2]
    output logic                m_axis_tuser    // answer_kind
);
    import ntpc_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    state_t        state_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic [63:0]   now_reg;
    logic          res_found_reg;
    logic [63:0]   res_value_reg;
    logic          m_valid_reg;
    logic          m_kind_reg;
    logic          m_ntp_reg;
    logic          m_found_reg;
    logic [63:0]   m_value_reg;

    logic          out_free;
    logic          m_load;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [63:0]   ram_rd_data;
    logic [64:0]   age;
    logic          fresh;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty && (q_head.take || out_free);
    assign ram_wr_en   = q_pop && !q_head.take && q_head.ntp;
    assign wr_ptr_next = (wr_ptr_reg == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // output register is loaded by a verdict pop or a finished take
    assign m_load = (state_reg == ST_IDLE && q_pop && !q_head.take) ||
                    (state_reg == ST_SEND && out_free);

    // age of the entry just read, borrow marks a stamp in the future
    assign age   = {1'b0, now_reg} - {1'b0, ram_rd_data};
    assign fresh = !age[64] && (age[63:0] < {32'h0, fresh_window});

    always_comb
    begin
        ram_rd_en = 1'b0;
        if (state_reg == ST_IDLE)
        begin
            ram_rd_en = q_pop && q_head.take && (fill_reg != '0);
        end
        else if (state_reg == ST_READ)
        begin
            ram_rd_en = !fresh && (fill_reg != '0);
        end
    end

    ntpc_ram #(
        .WIDTH (64),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (q_head.value),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            now_reg       <= '0;
            res_found_reg <= 1'b0;
            res_value_reg <= '0;
            m_valid_reg   <= 1'b0;
            m_kind_reg    <= KIND_VERDICT;
            m_ntp_reg     <= 1'b0;
            m_found_reg   <= 1'b0;
            m_value_reg   <= '0;
        end
        else
        begin
            if (m_axis_tready && !m_load)
            begin
                m_valid_reg <= 1'b0;
            end
            if (ram_rd_en)
            begin
                rd_ptr_reg <= rd_ptr_next;
                fill_reg   <= fill_reg - 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && q_head.take)
                    begin
                        now_reg <= q_head.value;
                        if (fill_reg == '0)
                        begin
                            res_found_reg <= 1'b0;
                            res_value_reg <= '0;
                            state_reg     <= ST_SEND;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    else if (q_pop)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_VERDICT;
                        m_ntp_reg   <= q_head.ntp;
                        m_found_reg <= 1'b0;
                        m_value_reg <= '0;
                        if (q_head.ntp)
                        begin
                            wr_ptr_reg <= wr_ptr_next;
                            // a full ring drops its oldest entry
                            if (fill_reg == FW'(RING_DEPTH))
                            begin
                                rd_ptr_reg <= rd_ptr_next;
                            end
                            else
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    if (fresh)
                    begin
                        res_found_reg <= 1'b1;
                        res_value_reg <= ram_rd_data;
                        state_reg     <= ST_SEND;
                    end
                    else if (fill_reg == '0)
                    begin
                        res_found_reg <= 1'b0;
                        res_value_reg <= '0;
                        state_reg     <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KIND_TAKE;
                        m_ntp_reg   <= 1'b0;
                        m_found_reg <= res_found_reg;
                        m_value_reg <= res_value_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {6'h00, m_value_reg, m_found_reg, m_ntp_reg};

    // fill count never passes the ring size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(RING_DEPTH))
        else $error("ring fill count above ring depth");

    // ring data is only examined in the cycle after a read was issued
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> $past(ram_rd_en))
        else $error("ring data checked without a preceding read");

    // a popped verdict shows up in the output register next cycle
    a_verdict_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_head.take |=> m_valid_reg && m_kind_reg == KIND_VERDICT)
        else $error("verdict not presented after pop");

    // a finished take leaves through the output register
    a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEND && out_free |=> m_valid_reg && m_kind_reg == KIND_TAKE)
        else $error("take answer not presented");

endmodule

FILE: hw/rtl/ntp_rx_timestamp_capture_core.sv
// ----------------------------------------------------------------------------
// ntp_rx_timestamp_capture_core
// classifies received frames as ntp and keeps their arrival stamps in a ring
// ----------------------------------------------------------------------------
// verdicts: queued at the last byte, then popped into the output register
// throughput: one frame byte per cycle while the operation queue has room
// a take request is popped, then walks the ring entries one by one through the
//   single ram read port, then its answer is loaded into the output register
// reset: asynchronous, active low; ring empty, udp_port 123, window 200000
//   stamp ram contents are not cleared, the fill count guards every read
// ----------------------------------------------------------------------------
module ntp_rx_timestamp_capture_core #(
    parameter int RING_DEPTH  = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // frame_byte[7:0], time_value[71:8]
    input  logic        s_axis_tuser,   // command: 0 frame byte, 1 take
    input  logic        s_axis_tlast,   // frame_end

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // is_ntp[0], stamp_found[1], stamp_value[65:2]
    output logic        m_axis_tuser,   // answer_kind: 0 verdict, 1 take answer

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ntpc_pkg::*;

    logic [15:0] udp_port_reg;
    logic [31:0] fresh_window_reg;
    logic        cfg_write;

    ntpc_op_t    push_op;
    ntpc_op_t    head_op;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // ------------------------------------------------------------------
    // register file: udp_port at 0x0, fresh_window at 0x4
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            udp_port_reg     <= UDP_PORT_RST;
            fresh_window_reg <= FRESH_WINDOW_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_UDP_PORT:     udp_port_reg     <= pwdata[15:0];
                REG_FRESH_WINDOW: fresh_window_reg <= pwdata;
                default:          udp_port_reg     <= udp_port_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_UDP_PORT:     prdata = {16'h0000, udp_port_reg};
            REG_FRESH_WINDOW: prdata = fresh_window_reg;
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front: byte parser, pushes verdicts and take requests in order
    // ------------------------------------------------------------------
    ntpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .udp_port      (udp_port_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (push_op)
    );

    // ------------------------------------------------------------------
    // queue: lets long take walks run while frame bytes keep streaming
    // ------------------------------------------------------------------
    ntpc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // ------------------------------------------------------------------
    // back: stamp ring and output register
    // ------------------------------------------------------------------
    ntpc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fresh_window  (fresh_window_reg),
        .q_empty       (q_empty),
        .q_head        (head_op),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: tb/ntpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntpc_checker
// watches the frame, result and register ports of the ntp capture core,
// predicts every verdict and take answer and compares them in order
// ----------------------------------------------------------------------------
module ntpc_checker #(
    parameter int RING_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // frame_byte[7:0], time_value[71:8]
    input  logic        s_axis_tuser,   // command
    input  logic        s_axis_tlast,   // frame_end

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // is_ntp[0], stamp_found[1], stamp_value[65:2]
    input  logic        m_axis_tuser,   // answer_kind

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          pending
);
    import ntpc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic        ntp;
        logic        found;
        logic [63:0] value;
    } answer_t;

    answer_t     answers_due[$];

    logic [15:0] port_reg;
    logic [31:0] window_reg;

    logic [63:0] stamp_ring [RING_DEPTH];
    int unsigned wr_idx;
    int unsigned rd_idx;
    int unsigned fill;

    // header parse state of the frame in progress
    logic [15:0] byte_cnt;
    logic [63:0] arrival;
    logic [15:0] etype;
    logic [4:0]  ip_off;
    logic [5:0]  hdr_len;
    logic        ver_ok;
    logic [7:0]  proto;
    logic [15:0] dport;

    // pops oldest entries until one is younger than the window
    task automatic take_stamp(input logic [63:0] now, output answer_t ans);
        logic [63:0] t;
        ans = '{KIND_TAKE, 1'b0, 1'b0, 64'd0};
        while (fill > 0 && !ans.found)
        begin
            t      = stamp_ring[rd_idx];
            rd_idx = (rd_idx + 1) % RING_DEPTH;
            fill--;
            if (now >= t && (now - t) < {32'd0, window_reg})
            begin
                ans.found = 1'b1;
                ans.value = t;
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last, input logic [63:0] tv);
        int unsigned pos;
        logic [16:0] len;
        logic        ntp;
        pos = byte_cnt;
        if (pos == 0)
        begin
            arrival = tv;
            etype   = '0;
            ip_off  = IP_OFF_PLAIN;
            hdr_len = '0;
            ver_ok  = 1'b0;
            proto   = '0;
            dport   = '0;
        end
        if (pos == 12)
            etype = {b, 8'h00};
        else if (pos == 13)
        begin
            etype[7:0] = b;
            if (etype == VLAN_TPID)
                ip_off = IP_OFF_VLAN;
        end
        else if (ip_off == IP_OFF_VLAN && pos == 16)
            etype = {b, 8'h00};
        else if (ip_off == IP_OFF_VLAN && pos == 17)
            etype[7:0] = b;
        if (pos == ip_off)
        begin
            ver_ok  = (b[7:4] == IP_VERSION4);
            hdr_len = {b[3:0], 2'b00};
        end
        if (pos == ip_off + 9)
            proto = b;
        if (pos > ip_off)
        begin
            if (pos == ip_off + hdr_len + 2)
                dport = {b, 8'h00};
            if (pos == ip_off + hdr_len + 3)
                dport[7:0] = b;
        end
        if (byte_cnt != 16'hFFFF)
            byte_cnt++;
        if (is_last)
        begin
            len = 17'(pos) + 17'd1;
            ntp = (len >= MIN_PLAIN_LEN)
                && !(ip_off == IP_OFF_VLAN && len < MIN_VLAN_LEN)
                && etype == ETYPE_IPV4 && ver_ok
                && hdr_len >= MIN_IHL_BYTES && len >= ip_off + hdr_len + 8
                && proto == PROTO_UDP && dport == port_reg;
            if (ntp)
            begin
                // full ring loses its oldest stamp
                if (fill >= RING_DEPTH)
                begin
                    rd_idx = (rd_idx + 1) % RING_DEPTH;
                    fill--;
                end
                stamp_ring[wr_idx] = arrival;
                wr_idx = (wr_idx + 1) % RING_DEPTH;
                fill++;
            end
            byte_cnt = '0;
            answers_due.push_back('{KIND_VERDICT, ntp, 1'b0, 64'd0});
        end
    endtask

    always @(posedge clk)
    begin : watch
        answer_t ans;
        logic    bad;
        if (!rst_n)
        begin
            port_reg   = UDP_PORT_RST;
            window_reg = FRESH_WINDOW_RST;
            wr_idx     = 0;
            rd_idx     = 0;
            fill       = 0;
            byte_cnt   = '0;
            arrival    = '0;
            etype      = '0;
            ip_off     = IP_OFF_PLAIN;
            hdr_len    = '0;
            ver_ok     = 1'b0;
            proto      = '0;
            dport      = '0;
            fail_count = 0;
            answers_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_UDP_PORT)
                    port_reg = pwdata[15:0];
                else
                    window_reg = pwdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == CMD_TAKE)
                begin
                    take_stamp(s_axis_tdata[71:8], ans);
                    answers_due.push_back(ans);
                end
                else
                    parse_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[71:8]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t unexpected result: tuser %0d tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    ans = answers_due.pop_front();
                    bad = 1'b0;
                    if (m_axis_tuser !== ans.kind)
                    begin
                        $display("%0t answer_kind: expected %0d, actual %0d",
                                 $time, ans.kind, m_axis_tuser);
                        bad = 1'b1;
                    end
                    if (m_axis_tdata[0] !== ans.ntp)
                    begin
                        $display("%0t is_ntp: expected %0d, actual %0d",
                                 $time, ans.ntp, m_axis_tdata[0]);
                        bad = 1'b1;
                    end
                    if (m_axis_tdata[1] !== ans.found)
                    begin
                        $display("%0t stamp_found: expected %0d, actual %0d",
                                 $time, ans.found, m_axis_tdata[1]);
                        bad = 1'b1;
                    end
                    if (m_axis_tdata[65:2] !== ans.value)
                    begin
                        $display("%0t stamp_value: expected %h, actual %h",
                                 $time, ans.value, m_axis_tdata[65:2]);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
        end
        pending = answers_due.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the ntp receive timestamp capture core: directed frames for
// every header and length rule, ring overflow and stale stamps, then random
// frame and take traffic under several register settings; a checker beside
// the core predicts and compares all results
// ----------------------------------------------------------------------------
module tb_top;
    import ntpc_pkg::*;

    localparam int RING_DEPTH = 8;
    // a take may walk the whole ring before its answer leaves
    localparam int SETTLE_CYCLES = RING_DEPTH + 8;

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // frame_byte[7:0], time_value[71:8]
    logic        s_axis_tuser;   // command: 0 frame byte, 1 take
    logic        s_axis_tlast;   // frame_end

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // is_ntp[0], stamp_found[1], stamp_value[65:2]
    logic        m_axis_tuser;   // answer_kind

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;

    // stimulus-side copies of the register values and the running time base
    logic [15:0] port_cfg;
    logic [31:0] win_cfg;
    logic [63:0] now_us;
    logic        idle_on;
    logic [7:0]  frame_buf[];

    ntp_rx_timestamp_capture_core #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ntpc_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop in case the core hangs
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall bursts while idling is on
    initial
    begin : result_stall
        int hold;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready = 1'b0;
                hold--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                hold = $urandom_range(0, 4);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // one input transfer, driven at the falling edge, held until accepted
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic is_last,
                             input logic [63:0] tv);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {tv, b};
        s_axis_tuser  = cmd;
        s_axis_tlast  = is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // frame_byte and frame_end carry noise on a take, the core ignores them
    task automatic send_take(input logic [63:0] tv);
        send_item(CMD_TAKE, 8'($urandom), 1'($urandom), tv);
    endtask

    function automatic void put_byte(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size())
            frame_buf[idx] = v;
    endfunction

    // random bytes with the header fields of interest laid over them,
    // fields past the end of a short frame are simply cut off
    task automatic make_frame(input int len, input logic vlan, input logic [15:0] etype,
                              input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] port);
        int off;
        frame_buf = new[len];
        foreach (frame_buf[i])
            frame_buf[i] = 8'($urandom);
        off = vlan ? 18 : 14;
        if (vlan)
        begin
            put_byte(12, VLAN_TPID[15:8]);
            put_byte(13, VLAN_TPID[7:0]);
        end
        put_byte(off - 2, etype[15:8]);
        put_byte(off - 1, etype[7:0]);
        put_byte(off, {ver, ihl});
        put_byte(off + 9, proto);
        put_byte(off + ihl * 4 + 2, port[15:8]);
        put_byte(off + ihl * 4 + 3, port[7:0]);
    endtask

    // the stamp rides on the first byte; take_at puts a take before the byte at that index
    task automatic send_frame(input logic [63:0] stamp, input int take_at,
                              input logic [63:0] take_tv);
        foreach (frame_buf[i])
        begin
            if (i == take_at)
                send_take(take_tv);
            send_item(CMD_BYTE, frame_buf[i], i == frame_buf.size() - 1,
                      i == 0 ? stamp : {$urandom, $urandom});
        end
    endtask

    task automatic frame_out(input int len, input logic vlan, input logic [15:0] etype,
                             input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] port,
                             input logic [63:0] stamp);
        make_frame(len, vlan, etype, ver, ihl, proto, port);
        send_frame(stamp, -1, 64'd0);
    endtask

    // let every expected result come out, then the core's own latency
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // setup cycle then access cycle, only while the core is idle
    task automatic cfg_write(input logic idx, input logic [31:0] value);
        settle();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_UDP_PORT)
            port_cfg = value[15:0];
        else
            win_cfg = value;
    endtask

    // take times cluster around the newest stamps so some are fresh,
    // some stale and some earlier than the stamps themselves
    function automatic logic [63:0] take_time();
        int unsigned step;
        step = (win_cfg >> 2) + 1;
        case ($urandom_range(0, 9))
            0, 1:    return now_us - $urandom_range(0, 3 * step);
            2:       return {$urandom, $urandom};
            default: return now_us + $urandom_range(0, step);
        endcase
    endfunction

    // mostly well-formed ntp frames with random content, the rest broken in
    // one field, cut short or pure noise; takes between and inside frames
    task automatic run_phase(input int n_items);
        int          sent;
        int          len;
        int          take_at;
        int unsigned step;
        logic        vlan;
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [63:0] stamp;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_take(take_time());
                sent++;
            end
            else
            begin
                vlan  = 1'($urandom);
                etype = ETYPE_IPV4;
                ver   = IP_VERSION4;
                ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
                proto = PROTO_UDP;
                port  = port_cfg;
                len   = (vlan ? 18 : 14) + ihl * 4 + 8 + $urandom_range(0, 10);
                case ($urandom_range(0, 13))
                    0: etype = 16'($urandom);
                    1: ver   = 4'($urandom);
                    2: ihl   = 4'($urandom_range(0, 4));
                    3: proto = 8'($urandom);
                    4: port  = 16'($urandom);
                    5: len   = $urandom_range(1, len - 1);
                    6:
                    begin
                        etype = 16'($urandom);
                        ver   = 4'($urandom);
                        ihl   = 4'($urandom);
                        proto = 8'($urandom);
                        port  = 16'($urandom);
                        len   = $urandom_range(1, 90);
                    end
                    default: ;
                endcase
                make_frame(len, vlan, etype, ver, ihl, proto, port);
                stamp = now_us;
                step  = (win_cfg >> 2) + 1;
                now_us = now_us + $urandom_range(0, step);
                take_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
                send_frame(stamp, take_at, take_time());
                sent += len;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_BYTE;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        port_cfg      = UDP_PORT_RST;
        win_cfg       = FRESH_WINDOW_RST;
        now_us        = {$urandom, $urandom};
        idle_on       = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // header and length rules under the reset settings
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd1000);
        frame_out(46, 1'b1, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd2000);
        frame_out(45, 1'b1, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd2100);
        frame_out(41, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd2200);
        frame_out(42, 1'b0, 16'h86DD, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd2300);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd6, 4'd5, PROTO_UDP, port_cfg, 64'd2400);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd4, PROTO_UDP, port_cfg, 64'd2500);
        // longest ip header: one byte short of room for the udp header, then exact
        frame_out(81, 1'b0, ETYPE_IPV4, 4'd4, 4'd15, PROTO_UDP, port_cfg, 64'd2600);
        frame_out(82, 1'b0, ETYPE_IPV4, 4'd4, 4'd15, PROTO_UDP, port_cfg, 64'd3000);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, 8'd6, port_cfg, 64'd3100);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg + 16'd1, 64'd3200);
        frame_out(1, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd3300);
        frame_out(2, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd3400);

        // ring holds 1000, 2000, 3000: fresh oldest, stale skip, then empty
        send_take(64'd1500);
        send_take(64'd202000);
        send_take(64'd0);

        // time extremes: stamp after now is stale, zero age is fresh
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'hFFFF_FFFF_FFFF_FFF0);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd0);
        send_take(64'd0);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, '1);
        send_take('1);
        frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd100);
        send_take(64'd50);

        // take in the middle of a frame must not upset its parse
        make_frame(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg);
        send_frame(64'd500, 20, 64'd500);
        send_take(64'd600);

        // ten stamps into an eight deep ring, the two oldest are lost
        for (int i = 0; i < 10; i++)
            frame_out(42, 1'b0, ETYPE_IPV4, 4'd4, 4'd5, PROTO_UDP, port_cfg, 64'd10000 + i);
        send_take(64'd10005);
        send_take(64'd210009);

        // random traffic under several settings, extremes first
        cfg_write(REG_UDP_PORT, 32'd0);
        cfg_write(REG_FRESH_WINDOW, 32'd1);
        run_phase(100);

        cfg_write(REG_UDP_PORT, 32'd65535);
        cfg_write(REG_FRESH_WINDOW, 32'hFFFF_FFFF);
        run_phase(100);

        cfg_write(REG_UDP_PORT, 32'($urandom_range(0, 65535)));
        cfg_write(REG_FRESH_WINDOW, 32'($urandom_range(1, 32'hFFFF_FFFF)));
        run_phase(100);

        // back to reset values, full rate on both sides
        cfg_write(REG_UDP_PORT, 32'(UDP_PORT_RST));
        cfg_write(REG_FRESH_WINDOW, FRESH_WINDOW_RST);
        idle_on = 1'b0;
        run_phase(100);

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: ntp_rx_timestamp_capture_core.f
hw/rtl/ntpc_pkg.sv
hw/rtl/ntpc_ram.sv
hw/rtl/ntpc_fifo.sv
hw/rtl/ntpc_front.sv
hw/rtl/ntpc_back.sv
hw/rtl/ntp_rx_timestamp_capture_core.sv
tb/ntpc_checker.sv
tb/tb_top.sv
